@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on the rising edge with an
// active-low reset that disables the check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/itar_pkg.sv @@
// ----------------------------------------------------------------------------
// itar_pkg
// Types and constants of the impact triggered accelerometer recorder.
// ----------------------------------------------------------------------------
package itar_pkg;

    localparam int S_TDATA_W  = 64;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 128;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // recorder status codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LISTEN = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_LOCKED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_IMPACT_LIMIT = 2'd0;
    localparam logic [1:0] REG_STILL_LIMIT  = 2'd1;
    localparam logic [1:0] REG_STILL_COUNT  = 2'd2;

    // input word, lowest field last
    typedef struct packed {
        logic [4:0]         pad;
        logic [9:0]         read_index;
        logic               arm;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
    } itar_in_t;

    // result word, lowest field last
    typedef struct packed {
        logic [3:0]         pad;
        logic signed [15:0] read_z;
        logic signed [15:0] read_y;
        logic signed [15:0] read_x;
        logic [31:0]        sample_magnitude;
        logic [31:0]        peak_magnitude;
        logic [9:0]         write_position;
        logic [1:0]         status;
    } itar_out_t;

endpackage

@@ hdl/impact_triggered_accel_recorder.sv @@
// Path: an accepted word is registered in stage A, then in the output register
// that drives m_tdata; a stall on m_tready can hold it in either register.
// Throughput: one word per cycle unless m_tready stalls (single store write port).
// Reset: aresetn (synchronous, active low) clears status, position, peak,
// countdown, pipeline valids and loads the register defaults; the sample store
// is not cleared.
// ----------------------------------------------------------------------------
// impact_triggered_accel_recorder
// Ring buffer of three-axis samples with peak tracking and an impact/still
// lock sequence.
// ----------------------------------------------------------------------------
module impact_triggered_accel_recorder #(
    parameter int BUFFER_DEPTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tdata: accel_x, accel_y, accel_z, arm, read_index, zero pad
    input  logic [itar_pkg::S_TDATA_W-1:0]     s_tdata,
    // tuser: operation
    input  logic [itar_pkg::S_TUSER_W-1:0]     s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: status, write_position, peak_magnitude, sample_magnitude,
    //        read_x, read_y, read_z, zero pad
    output logic [itar_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [itar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [itar_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import itar_pkg::*;

    localparam int          AW        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [31:0] DEPTH_32  = 32'(BUFFER_DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(BUFFER_DEPTH - 1);

    function automatic logic [30:0] square16(input logic [15:0] v);
        logic [16:0] m;
        logic [33:0] p;
        m = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
        p = 34'(m) * 34'(m);
        return p[30:0];
    endfunction

    // configuration
    logic [31:0] impact_limit_reg;
    logic [31:0] still_limit_reg;
    logic [15:0] still_needed_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            impact_limit_reg <= 32'd3221225472;
            still_limit_reg  <= 32'd0;
            still_needed_reg <= 16'd1000;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_IMPACT_LIMIT: impact_limit_reg <= cfg_data;
                REG_STILL_LIMIT:  still_limit_reg  <= cfg_data;
                REG_STILL_COUNT:  still_needed_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // stage A: squares and store read
    itar_in_t        in_word;
    logic [31:0]     idx_32;
    logic [AW-1:0]   rd_addr;
    logic            s_accept;

    logic            a_valid_reg;
    logic [1:0]      a_op_reg;
    logic            a_arm_reg;
    logic [47:0]     a_sample_reg;
    logic [30:0]     a_sqx_reg, a_sqy_reg, a_sqz_reg;
    logic            a_rd_ok_reg;
    logic            a_fwd_reg;
    logic [47:0]     a_fwd_data_reg;
    logic [47:0]     rd_q_reg;

    // stage B: state update
    logic            b_fire;
    logic            b_wr_en;
    logic [1:0]      status_reg, status_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [31:0]     peak_reg, peak_next;
    logic [15:0]     cd_reg, cd_next;
    logic [31:0]     mag_sum;
    logic [31:0]     sample_mag;
    logic [47:0]     rd_word;
    logic [15:0]     rx, ry, rz;
    logic [31:0]     pos_32;
    itar_out_t       out_word;

    logic [47:0]     mem [BUFFER_DEPTH];

    logic            m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign in_word  = itar_in_t'(s_tdata);
    assign idx_32   = 32'(in_word.read_index);
    assign rd_addr  = idx_32[AW-1:0];
    assign b_fire   = a_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !a_valid_reg || b_fire;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
        end else if (b_fire) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_op_reg       <= s_tuser;
            a_arm_reg      <= in_word.arm;
            a_sample_reg   <= {in_word.accel_z, in_word.accel_y, in_word.accel_x};
            a_sqx_reg      <= square16(in_word.accel_x);
            a_sqy_reg      <= square16(in_word.accel_y);
            a_sqz_reg      <= square16(in_word.accel_z);
            a_rd_ok_reg    <= idx_32 < DEPTH_32;
            // store write of the item leaving stage A lands this same edge
            a_fwd_reg      <= b_fire && b_wr_en && (pos_reg == rd_addr);
            a_fwd_data_reg <= a_sample_reg;
        end
    end

    // sample store
    always_ff @(posedge aclk) begin
        if (b_fire && b_wr_en) begin
            mem[pos_reg] <= a_sample_reg;
        end
        if (s_accept) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    assign mag_sum = 32'(a_sqx_reg) + 32'(a_sqy_reg) + 32'(a_sqz_reg);
    assign rd_word = a_fwd_reg ? a_fwd_data_reg : rd_q_reg;

    always_comb begin
        logic [1:0]  st;
        logic [15:0] cd;
        st          = status_reg;
        cd          = cd_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        peak_next   = peak_reg;
        cd_next     = cd_reg;
        sample_mag  = 32'd0;
        b_wr_en     = 1'b0;
        rx          = 16'd0;
        ry          = 16'd0;
        rz          = 16'd0;
        unique case (a_op_reg)
            OP_SAMPLE: begin
                if (st == ST_IDLE && a_arm_reg) begin
                    st = ST_LISTEN;
                end
                if (st != ST_LOCKED) begin
                    b_wr_en    = 1'b1;
                    pos_next   = (pos_reg == LAST_POS) ? '0 : pos_reg + AW'(1);
                    sample_mag = mag_sum;
                    if (mag_sum > peak_reg) begin
                        peak_next = mag_sum;
                    end
                    if (st != ST_IDLE) begin
                        if (mag_sum >= impact_limit_reg) begin
                            st = ST_WAIT;
                            cd = still_needed_reg;
                        end
                        // impact and still in one sample: reload, then count
                        if (st == ST_WAIT) begin
                            if (mag_sum <= still_limit_reg) begin
                                cd = cd - 16'd1;
                            end
                            if (cd == 16'd0) begin
                                st = ST_LOCKED;
                            end
                        end
                    end
                    status_next = st;
                    cd_next     = cd;
                end
            end
            OP_READ: begin
                if (a_rd_ok_reg) begin
                    rx = rd_word[15:0];
                    ry = rd_word[31:16];
                    rz = rd_word[47:32];
                end
            end
            OP_CLEAR: begin
                status_next = ST_IDLE;
                pos_next    = '0;
            end
            default: ;
        endcase
    end

    assign pos_32 = 32'(pos_next);

    always_comb begin
        out_word                  = '0;
        out_word.status           = status_next;
        out_word.write_position   = pos_32[9:0];
        out_word.peak_magnitude   = peak_next;
        out_word.sample_magnitude = sample_mag;
        out_word.read_x           = rx;
        out_word.read_y           = ry;
        out_word.read_z           = rz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= ST_IDLE;
            pos_reg    <= '0;
            peak_reg   <= 32'd0;
            cd_reg     <= 16'd0;
        end else if (b_fire) begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            peak_reg   <= peak_next;
            cd_reg     <= cd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (b_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire) begin
            m_tdata_reg <= M_TDATA_W'(out_word);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ hdl/itar_checker.sv @@
// ----------------------------------------------------------------------------
// itar_checker
// Port-level checks of the recorder's result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itar_checker #(
    parameter int BUFFER_DEPTH = 1024
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic [itar_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready
);
    import itar_pkg::*;

    itar_out_t   ow;
    logic [31:0] wpos_32;
    logic        read_nonzero;

    assign ow           = itar_out_t'(m_tdata);
    assign wpos_32      = 32'(ow.write_position);
    assign read_nonzero = (ow.read_x != 16'd0) || (ow.read_y != 16'd0)
                       || (ow.read_z != 16'd0);

    // stalled word holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata))

    `ASSERT_IMPL(a_peak_ge_sample, aclk, aresetn, m_tvalid,
                 ow.peak_magnitude >= ow.sample_magnitude)

    // a word carries either a sample or a read-back, never both
    `ASSERT_IMPL(a_read_xor_sample, aclk, aresetn, m_tvalid && read_nonzero,
                 ow.sample_magnitude == 32'd0)

    `ASSERT_IMPL(a_wpos_range, aclk, aresetn, m_tvalid && (BUFFER_DEPTH <= 1024),
                 wpos_32 < 32'(BUFFER_DEPTH))

endmodule

bind impact_triggered_accel_recorder itar_checker #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
) u_itar_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tdata (m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
);
